FILE: rtl/olie_pkg.sv
// Package for the ordered list insert/erase unit: sizes, operation and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package olie_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] OP_APPEND      = 3'd0;
  localparam logic [2:0] OP_INSERT      = 3'd1;
  localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
  localparam logic [2:0] OP_ERASE       = 3'd3;
  localparam logic [2:0] OP_READ        = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the request
    logic capture;    // latch status and default read data
    logic wr_tail;    // write value at entry_count
    logic wr_pos;     // write value at position
    logic setup_up;   // prepare shift toward higher indexes
    logic setup_dn;   // prepare shift toward lower indexes
    logic shift;      // run one shift step
    logic take_rdata; // latch memory read data as result
    logic inc;
    logic dec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] code;
    logic       shift_done;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/olie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module olie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/olie_datapath.sv
// Datapath: request registers, entry count, shift pointers, result registers
// and the entry store. Depends on olie_pkg and olie_ram.
`default_nettype none

module olie_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire olie_pkg::dp_cmd_t     cmd,
  output      olie_pkg::dp_sts_t     sts,
  input  wire logic [2:0]            operation,
  input  wire logic [4:0]            position,
  input  wire logic signed [31:0]    value,
  output      logic signed [31:0]    read_data,
  output      logic [4:0]            count,
  output      logic [1:0]            status
);

  import olie_pkg::*;

  logic [2:0]       op_q;
  logic [POS_W-1:0] pos_q;
  logic [31:0]      val_q;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] remain;
  logic             pend;
  logic             up;
  logic [IDX_W-1:0] src;
  logic [IDX_W-1:0] dst;
  logic [31:0]      read_data_q;
  logic [1:0]       status_q;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             full;
  logic             empty;
  logic [1:0]       code;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] cnt_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  assign cnt_ext = CMP_W'(entry_count);
  assign pos_ext = CMP_W'(pos_q);
  assign full    = (cnt_ext >= CMP_W'(CAPACITY));
  assign empty   = (entry_count == '0);
  assign pos_idx = IDX_W'(pos_q);
  assign cnt_idx = IDX_W'(entry_count);

  // status of the latched request against the current count
  always_comb begin
    code = ST_OK;
    case (op_q)
      OP_APPEND: begin
        if (full) code = ST_FULL;
      end
      OP_INSERT: begin
        if (full) code = ST_FULL;
        else if (pos_ext > cnt_ext) code = ST_RANGE;
      end
      OP_REMOVE_LAST: begin
        if (empty) code = ST_EMPTY;
      end
      OP_ERASE, OP_READ: begin
        if (pos_ext >= cnt_ext) code = ST_RANGE;
      end
      default: code = ST_OK;
    endcase
  end

  // a pending move has priority on the write port; reads follow the position
  // except while shifting
  always_comb begin
    ram_we    = (cmd.shift && pend) || cmd.wr_tail || cmd.wr_pos;
    ram_waddr = pos_idx;
    ram_wdata = val_q;
    if (cmd.shift && pend) begin
      ram_waddr = dst;
      ram_wdata = ram_rdata;
    end else if (cmd.wr_tail) begin
      ram_waddr = cnt_idx;
    end
    ram_raddr = cmd.shift ? src : pos_idx;
  end

  olie_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      remain      <= '0;
      pend        <= 1'b0;
    end else begin
      if (cmd.inc) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.dec) begin
        entry_count <= entry_count - 1'b1;
      end
      if (cmd.setup_up) begin
        remain <= CNT_W'(cnt_ext - pos_ext);
        pend   <= 1'b0;
      end else if (cmd.setup_dn) begin
        remain <= CNT_W'(cnt_ext - pos_ext - 1'b1);
        pend   <= 1'b0;
      end else if (cmd.shift) begin
        if (remain != '0) begin
          remain <= remain - 1'b1;
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      pos_q <= position;
      val_q <= value;
    end
    if (cmd.setup_up) begin
      up  <= 1'b1;
      src <= IDX_W'(cnt_ext - 1'b1);
    end else if (cmd.setup_dn) begin
      up  <= 1'b0;
      src <= IDX_W'(pos_ext + 1'b1);
    end else if (cmd.shift && remain != '0) begin
      dst <= up ? src + 1'b1 : src - 1'b1;
      src <= up ? src - 1'b1 : src + 1'b1;
    end
    if (cmd.capture) begin
      status_q    <= code;
      read_data_q <= (op_q == OP_READ && code == ST_RANGE) ? '1 : '0;
    end else if (cmd.take_rdata) begin
      read_data_q <= ram_rdata;
    end
  end

  assign sts.op         = op_q;
  assign sts.code       = code;
  assign sts.shift_done = (remain == '0) && !pend;

  assign read_data = read_data_q;
  assign count     = 5'(entry_count);
  assign status    = status_q;

endmodule

`default_nettype wire

FILE: rtl/olie_ctrl.sv
// Controller state machine: sequences each request through the datapath.
// Depends on olie_pkg.
`default_nettype none

module olie_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  output      logic              done,
  input  wire olie_pkg::dp_sts_t sts,
  output      olie_pkg::dp_cmd_t cmd
);

  import olie_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
        if (sts.code == ST_OK) begin
          case (sts.op)
            OP_APPEND: begin
              cmd.wr_tail = 1'b1;
              cmd.inc     = 1'b1;
            end
            OP_INSERT: begin
              cmd.setup_up = 1'b1;
              state_next   = S_SHIFT;
            end
            OP_REMOVE_LAST: cmd.dec = 1'b1;
            OP_ERASE: begin
              cmd.setup_dn = 1'b1;
              state_next   = S_SHIFT;
            end
            OP_READ: state_next = S_READ;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_next = S_DONE;
          if (sts.op == OP_INSERT) begin
            cmd.wr_pos = 1'b1;
            cmd.inc    = 1'b1;
          end else begin
            cmd.dec = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.take_rdata = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ordered_list_insert_erase_unit.sv
// Append, remove last, rejected or unused requests go from the execute state
// to the done state; a read goes through the read state before done. Insert
// or erase passes through the shift state, where entries move one per cycle
// through the single read and single write port of the store.
// A new request is taken in the cycle after done. Reset empties the list
// (count zero); the store contents are left as they are, no clearing pass.
`default_nettype none

module ordered_list_insert_erase_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [2:0]         operation,
  input  wire logic [4:0]         position,
  input  wire logic signed [31:0] value,
  output      logic               done,
  output      logic signed [31:0] read_data,
  output      logic [4:0]         count,
  output      logic [1:0]         status
);

  import olie_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  olie_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .sts  (sts),
    .cmd  (cmd)
  );

  olie_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .operation(operation),
    .position (position),
    .value    (value),
    .read_data(read_data),
    .count    (count),
    .status   (status)
  );

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request taken without going busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while idle");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == 5'(CAPACITY)))
    else $error("full status with list not full");
`endif

endmodule

`default_nettype wire

FILE: tb/ordered_list_insert_erase_unit_test.sv
// Self-checking testbench for ordered_list_insert_erase_unit: directed edge cases,
// then biased random list traffic checked against a shadow copy of the list.
// Depends on olie_pkg and the RTL top level only.
module ordered_list_insert_erase_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olie_pkg::*;

  // opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 2 * CAPACITY + 8;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [4:0]         count;
    logic [1:0]         status;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         operation = OP_APPEND;
  logic [4:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] read_data;
  logic [4:0]         count;
  logic [1:0]         status;

  // shadow copy of the list
  logic signed [31:0] shadow_words [CAPACITY];
  logic [CNT_W-1:0]   shadow_count = '0;
  list_result_t       pending_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int cycles = 0;
  int op_hits [8];
  int status_hits [4];

  ordered_list_insert_erase_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .position(position),
    .value(value),
    .done(done),
    .read_data(read_data),
    .count(count),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("ordered_list_insert_erase_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH result %0d %s: got %h want %h", results_checked, what, got, want);
  endtask

  // Updates the shadow list for one accepted transfer and returns the result it owes.
  function automatic list_result_t apply_to_list(input logic [2:0] op, input logic [4:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t res;
    int i;
    res.read_data = '0;
    res.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[IDX_W'(shadow_count)] = val;
          shadow_count++;
        end
      end
      OP_INSERT: begin
        // full wins over a bad position
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos > shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(shadow_count); i > int'(pos); i--)
            shadow_words[IDX_W'(i)] = shadow_words[IDX_W'(i - 1)];
          shadow_words[IDX_W'(pos)] = val;
          shadow_count++;
        end
      end
      OP_REMOVE_LAST: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      OP_ERASE: begin
        if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(pos) + 1; i < int'(shadow_count); i++)
            shadow_words[IDX_W'(i - 1)] = shadow_words[IDX_W'(i)];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (pos >= shadow_count) begin
          res.read_data = -32'sd1;
          res.status = ST_RANGE;
        end else begin
          res.read_data = shadow_words[IDX_W'(pos)];
        end
      end
      default: begin
      end
    endcase
    res.count = 5'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("with nothing pending", read_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data) report_mismatch("read_data", read_data, want.read_data);
        if (count !== want.count) report_mismatch("count", 32'(count), 32'(want.count));
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
      end
      results_checked++;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with start
  // still high, so a following item is presented without start dropping.
  task automatic send_item(input logic [2:0] op, input logic [4:0] pos,
                           input logic signed [31:0] val);
    list_result_t res;
    start <= 1'b1;
    operation <= op;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = apply_to_list(op, pos, val);
    pending_results.insert(pending_results.size(), res);
    op_hits[op]++;
    status_hits[res.status]++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_list();
    send_item(OP_READ, 5'd0, 32'sd0);
    send_item(OP_REMOVE_LAST, 5'd0, 32'sd0);
    send_item(OP_ERASE, 5'd0, 32'sd0);
    send_item(OP_INSERT, 5'd1, 32'sd7);
  endtask

  task automatic test_spare_codes();
    send_item(OP_SPARE_A, 5'd31, -32'sd1);
    send_item(OP_SPARE_B, 5'd0, 32'sh7FFF_FFFF);
    send_item(OP_SPARE_C, 5'd16, 32'sh8000_0000);
  endtask

  task automatic test_positional_edits();
    send_item(OP_APPEND, 5'd0, 32'sh8000_0000);
    send_item(OP_APPEND, 5'd0, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 5'd0, -32'sd1);
    send_item(OP_INSERT, 5'd3, 32'sd0);       // position equal to count appends
    send_item(OP_READ, 5'd0, 32'sd0);
    send_item(OP_READ, 5'd4, 32'sd0);
    send_item(OP_ERASE, 5'd0, 32'sd0);
    send_item(OP_ERASE, 5'd2, 32'sd0);        // last entry, nothing moves
    send_item(OP_ERASE, 5'd2, 32'sd0);
  endtask

  task automatic test_full_list();
    int i;
    // alternate head inserts and appends so the fill also runs long shifts
    for (i = int'(shadow_count); i < CAPACITY; i++) begin
      if (i % 2 == 1) send_item(OP_INSERT, 5'd0, 32'sd1 <<< i);
      else send_item(OP_APPEND, 5'd0, ~(32'sd1 <<< i));
    end
    send_item(OP_APPEND, 5'd0, 32'sd5);
    send_item(OP_INSERT, 5'd20, 32'sd5);      // full reported ahead of range
    send_item(OP_READ, 5'(CAPACITY - 1), 32'sd0);
    send_item(OP_ERASE, 5'd0, 32'sd0);
    send_item(OP_REMOVE_LAST, 5'd0, 32'sd0);
  endtask

  // Random walk that sweeps the list between empty and full; real operations count toward
  // the target, spare codes do not.
  task automatic test_random_traffic(input int target);
    int sent;
    int burst;
    int r;
    int held;
    int since_drain;
    bit growing;
    logic [2:0] op;
    logic [4:0] pos;
    logic signed [31:0] val;
    sent = 0;
    since_drain = 0;
    growing = 1'b1;
    while (sent < target) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        held = int'(shadow_count);
        if (held == CAPACITY) growing = 1'b0;
        else if (held == 0) growing = 1'b1;
        r = $urandom_range(0, 99);
        if (growing) begin
          if (r < 30) op = OP_APPEND;
          else if (r < 60) op = OP_INSERT;
          else if (r < 72) op = OP_READ;
          else if (r < 80) op = OP_ERASE;
          else if (r < 86) op = OP_REMOVE_LAST;
          else if (r < 92) op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
          else op = 3'($urandom_range(OP_APPEND, OP_SPARE_C));
        end else begin
          if (r < 30) op = OP_ERASE;
          else if (r < 48) op = OP_REMOVE_LAST;
          else if (r < 66) op = OP_READ;
          else if (r < 76) op = OP_APPEND;
          else if (r < 86) op = OP_INSERT;
          else if (r < 92) op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
          else op = 3'($urandom_range(OP_APPEND, OP_SPARE_C));
        end
        r = $urandom_range(0, 9);
        if (r < 2) pos = 5'($urandom);
        else if (op == OP_INSERT) pos = 5'($urandom_range(0, held));
        else if (held == 0) pos = '0;
        else pos = 5'($urandom_range(0, held - 1));
        case ($urandom_range(0, 7))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7FFF_FFFF;
          2: val = -32'sd1;
          3: val = 32'sd0;
          4: val = 32'($urandom_range(0, 255));
          default: val = 32'($urandom);
        endcase
        send_item(op, pos, val);
        if (op <= OP_READ) sent++;
      end
      r = $urandom_range(0, 9);
      if (r >= 3 && r < 9) idle_cycles($urandom_range(1, 5));
      else if (r == 9) idle_cycles($urandom_range(10, 30));
      since_drain += burst;
      if (since_drain > 250) begin
        wait_for_results();
        since_drain = 0;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_list();
    test_spare_codes();
    wait_for_results();
    test_positional_edits();
    test_full_list();
    wait_for_results();
    test_random_traffic(1180);
    wait_for_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    $write("covered %0d transfers: %0d append, %0d insert, %0d remove-last, ",
           op_hits.sum(), op_hits[OP_APPEND], op_hits[OP_INSERT], op_hits[OP_REMOVE_LAST]);
    $display("%0d erase, %0d read, %0d spare-code",
             op_hits[OP_ERASE], op_hits[OP_READ],
             op_hits[OP_SPARE_A] + op_hits[OP_SPARE_B] + op_hits[OP_SPARE_C]);
    $display("status seen: %0d ok, %0d full, %0d empty, %0d out of range; %0d results checked",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_RANGE], results_checked);
    if (mismatches == 0)
      $display("ordered_list_insert_erase_unit verification clean");
    else
      $display("ordered_list_insert_erase_unit verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/olie_pkg.sv
rtl/olie_ram.sv
rtl/olie_datapath.sv
rtl/olie_ctrl.sv
rtl/ordered_list_insert_erase_unit.sv
tb/ordered_list_insert_erase_unit_test.sv
